/* hw/rtl/hsvrgb_pkg.sv */
// Shared types and codes for the HSV to RGB converter.
// Depends on nothing; used by the front, queue, back and top-level modules.
`default_nettype none

package hsvrgb_pkg;

   localparam int unsigned HueW    = 9;
   localparam int unsigned PctW    = 7;
   localparam int unsigned ChanW   = 8;
   localparam int unsigned SectorW = 3;
   localparam int unsigned RemW    = 6;

   // Hue sector codes, one for each 60-degree slice of the color wheel.
   localparam logic [SectorW-1:0] SecRedYel = 3'd0;
   localparam logic [SectorW-1:0] SecYelGrn = 3'd1;
   localparam logic [SectorW-1:0] SecGrnCyn = 3'd2;
   localparam logic [SectorW-1:0] SecCynBlu = 3'd3;
   localparam logic [SectorW-1:0] SecBluMag = 3'd4;
   localparam logic [SectorW-1:0] SecMagRed = 3'd5;

   localparam logic [PctW-1:0] PctMax    = 7'd100;
   localparam logic [RemW-1:0] SectorDeg = 6'd60;

   // One classified color, as it sits in the queue.
   typedef struct packed {
      logic [SectorW-1:0] sector;
      logic [RemW-1:0]    rem;
      logic [PctW-1:0]    sat;
      logic [PctW-1:0]    val;
   } item_type;

   // A queue port: an item and the flag that says it is there.
   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

endpackage

`default_nettype wire

/* hw/rtl/hsvrgb_front.sv */
// Front end of the HSV to RGB converter: clamps the inputs and classifies the hue.
// Depends on hsvrgb_pkg; feeds hsvrgb_queue.
`default_nettype none

module hsvrgb_front (
   input  wire logic                         start,
   input  wire logic                         queue_full,
   input  wire logic [hsvrgb_pkg::HueW-1:0]  req_hue_deg,
   input  wire logic [hsvrgb_pkg::PctW-1:0]  req_sat_pct,
   input  wire logic [hsvrgb_pkg::PctW-1:0]  req_val_pct,
   output hsvrgb_pkg::link_type              push
);

   localparam logic [hsvrgb_pkg::HueW-1:0] HueMax = 9'd360;

   logic [hsvrgb_pkg::HueW-1:0]    hue_c;
   logic [hsvrgb_pkg::HueW-1:0]    base;
   logic [hsvrgb_pkg::SectorW-1:0] sector;

   // Hue of 360 and above wraps to 0, which is red.
   assign hue_c = (req_hue_deg >= HueMax) ? '0 : req_hue_deg;

   always_comb begin
      priority if (hue_c < 9'd60) begin
         sector = hsvrgb_pkg::SecRedYel;
         base   = 9'd0;
      end else if (hue_c < 9'd120) begin
         sector = hsvrgb_pkg::SecYelGrn;
         base   = 9'd60;
      end else if (hue_c < 9'd180) begin
         sector = hsvrgb_pkg::SecGrnCyn;
         base   = 9'd120;
      end else if (hue_c < 9'd240) begin
         sector = hsvrgb_pkg::SecCynBlu;
         base   = 9'd180;
      end else if (hue_c < 9'd300) begin
         sector = hsvrgb_pkg::SecBluMag;
         base   = 9'd240;
      end else begin
         sector = hsvrgb_pkg::SecMagRed;
         base   = 9'd300;
      end
   end

   always_comb begin
      push.valid       = start & ~queue_full;
      push.item.sector = sector;
      push.item.rem    = hsvrgb_pkg::RemW'(hue_c - base);
      push.item.sat    = (req_sat_pct > hsvrgb_pkg::PctMax) ? hsvrgb_pkg::PctMax : req_sat_pct;
      push.item.val    = (req_val_pct > hsvrgb_pkg::PctMax) ? hsvrgb_pkg::PctMax : req_val_pct;
   end

endmodule

`default_nettype wire

/* hw/rtl/hsvrgb_queue.sv */
// Short first-in first-out queue between the front and back of the converter.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_queue #(
   parameter int unsigned Depth = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  hsvrgb_pkg::link_type    push,
   input  wire logic               pop,
   output hsvrgb_pkg::link_type    head,
   output logic                    full
);

   localparam int unsigned PtrW = $clog2(Depth);
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   hsvrgb_pkg::item_type mem_ff [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == FullCnt);
   assign do_push = push.valid & ~full;
   assign do_pop  = pop & (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* hw/rtl/hsvrgb_back.sv */
// Back end of the HSV to RGB converter: a four-stage arithmetic pipeline and
// the output register. Depends on hsvrgb_pkg; takes items from hsvrgb_queue.
`default_nettype none

module hsvrgb_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  hsvrgb_pkg::link_type               head,
   output logic                               pop,
   output logic                               rsp_valid,
   output logic [hsvrgb_pkg::ChanW-1:0]       rsp_red,
   output logic [hsvrgb_pkg::ChanW-1:0]       rsp_green,
   output logic [hsvrgb_pkg::ChanW-1:0]       rsp_blue
);

   // Channel slots: 255*v, 255*p, 255*q and 255*t.
   localparam int unsigned ChV = 0;
   localparam int unsigned ChP = 1;
   localparam int unsigned ChQ = 2;
   localparam int unsigned ChT = 3;
   localparam int unsigned NumCh = 4;

   localparam int unsigned XW    = 13;  // up to 6000
   localparam int unsigned YW    = 20;  // up to 600000
   localparam int unsigned NW    = 24;  // 17*y + 20000
   localparam int unsigned MW    = 18;  // n / 64
   localparam int unsigned RecW  = 19;
   localparam int unsigned ProdW = MW + RecW;

   localparam logic [XW-1:0]   FixFull   = 13'd6000;
   localparam logic [NW-1:0]   RoundBias = 24'd20000;
   localparam logic [NW-1:0]   Mul17     = 24'd17;
   // floor(m / 625) == (m * RecipMul) >> 28, exact for m below 2**18.
   localparam logic [RecW-1:0] RecipMul  = 19'd429497;

   // Channel = floor((17*y + 20000) / 40000) = floor(floor(n/64) / 625).

   // The queue never waits on this side: the pipeline takes its head every cycle.
   assign pop = head.valid;

   logic [3:0] vld_ff, vld_in;
   logic       out_vld_ff;

   logic [hsvrgb_pkg::SectorW-1:0] sec_ff [4];
   logic [hsvrgb_pkg::PctW-1:0]    s1_val_ff;
   logic [XW-1:0]                  x_ff [NumCh];
   logic [YW-1:0]                  y_ff [NumCh];
   logic [MW-1:0]                  m_ff [NumCh];
   logic [hsvrgb_pkg::ChanW-1:0]   c_ff [NumCh];

   logic [XW-1:0]                  x_in [NumCh];
   logic [YW-1:0]                  y_in [NumCh];
   logic [MW-1:0]                  m_in [NumCh];
   logic [hsvrgb_pkg::ChanW-1:0]   c_in [NumCh];
   logic [NW-1:0]                  n_w  [NumCh];
   logic [ProdW-1:0]               prod_w [NumCh];

   logic [XW-1:0] sr_w, st_w, pd_w;

   logic [hsvrgb_pkg::ChanW-1:0] red_in, green_in, blue_in;
   logic [hsvrgb_pkg::ChanW-1:0] red_ff, green_ff, blue_ff;

   // Stage 1: the fractional terms s*r and s*(60-r), and (100-s)*60.
   always_comb begin
      sr_w = XW'(head.item.sat) * XW'(head.item.rem);
      st_w = XW'(head.item.sat) * XW'(hsvrgb_pkg::SectorDeg - head.item.rem);
      pd_w = XW'(hsvrgb_pkg::PctMax - head.item.sat) * XW'(hsvrgb_pkg::SectorDeg);
      x_in[ChV] = FixFull;
      x_in[ChP] = pd_w;
      x_in[ChQ] = FixFull - sr_w;
      x_in[ChT] = FixFull - st_w;
   end

   // Stages 2 to 4: scale by value, add the rounding bias, divide by 40000.
   always_comb begin
      for (int i = 0; i < NumCh; i++) begin
         y_in[i]   = YW'(s1_val_ff) * YW'(x_ff[i]);
         n_w[i]    = NW'(y_ff[i]) * Mul17 + RoundBias;
         m_in[i]   = n_w[i][NW-1:NW-MW];
         prod_w[i] = ProdW'(m_ff[i]) * ProdW'(RecipMul);
         c_in[i]   = prod_w[i][35:28];
      end
   end

   // Output: route the four candidates to the channels by sector.
   always_comb begin
      unique case (sec_ff[3])
         hsvrgb_pkg::SecRedYel: begin
            red_in = c_ff[ChV]; green_in = c_ff[ChT]; blue_in = c_ff[ChP];
         end
         hsvrgb_pkg::SecYelGrn: begin
            red_in = c_ff[ChQ]; green_in = c_ff[ChV]; blue_in = c_ff[ChP];
         end
         hsvrgb_pkg::SecGrnCyn: begin
            red_in = c_ff[ChP]; green_in = c_ff[ChV]; blue_in = c_ff[ChT];
         end
         hsvrgb_pkg::SecCynBlu: begin
            red_in = c_ff[ChP]; green_in = c_ff[ChQ]; blue_in = c_ff[ChV];
         end
         hsvrgb_pkg::SecBluMag: begin
            red_in = c_ff[ChT]; green_in = c_ff[ChP]; blue_in = c_ff[ChV];
         end
         default: begin
            red_in = c_ff[ChV]; green_in = c_ff[ChP]; blue_in = c_ff[ChQ];
         end
      endcase
   end

   // One valid bit per arithmetic stage, so the strobe lines up with the output register.
   assign vld_in = {vld_ff[2:0], head.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      sec_ff[0] <= head.item.sector;
      sec_ff[1] <= sec_ff[0];
      sec_ff[2] <= sec_ff[1];
      sec_ff[3] <= sec_ff[2];
      s1_val_ff <= head.item.val;
      x_ff      <= x_in;
      y_ff      <= y_in;
      m_ff      <= m_in;
      c_ff      <= c_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

`default_nettype wire

/* hw/rtl/hsv_to_rgb_converter.sv */
// Top level of the HSV to RGB converter: front end, queue and back end.
// Depends on hsvrgb_pkg, hsvrgb_front, hsvrgb_queue and hsvrgb_back.
`default_nettype none

// Converts one color per clock from hue (whole degrees), saturation and value
// (whole percent) to 8-bit red, green and blue. A transaction is accepted at
// a rising edge where start is high and busy is low; its result appears on
// the rsp_ ports, marked by rsp_valid, for exactly one cycle, in the order
// the transactions were accepted. The receiver cannot stall, and the back end
// drains the queue every cycle, so busy stays low and a new transaction may
// be started on every clock. A result passes through the queue, four
// arithmetic stages (fraction terms, scaling by value, rounding bias,
// division by a reciprocal multiply) and the output register. Hue at or above
// 360 is read as red, saturation and value above 100 are clamped, and zero
// saturation gives grey.
module hsv_to_rgb_converter #(
   parameter int unsigned QueueDepth = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [hsvrgb_pkg::HueW-1:0]   req_hue_deg,
   input  wire logic [hsvrgb_pkg::PctW-1:0]   req_sat_pct,
   input  wire logic [hsvrgb_pkg::PctW-1:0]   req_val_pct,
   output logic                               rsp_valid,
   output logic [hsvrgb_pkg::ChanW-1:0]       rsp_red,
   output logic [hsvrgb_pkg::ChanW-1:0]       rsp_green,
   output logic [hsvrgb_pkg::ChanW-1:0]       rsp_blue
);

   hsvrgb_pkg::link_type push;
   hsvrgb_pkg::link_type head;
   logic                 pop;
   logic                 queue_full;

   // Busy only reflects a full queue.
   assign busy = queue_full;

   hsvrgb_front u_front (
      .start       (start),
      .queue_full  (queue_full),
      .req_hue_deg (req_hue_deg),
      .req_sat_pct (req_sat_pct),
      .req_val_pct (req_val_pct),
      .push        (push)
   );

   hsvrgb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   hsvrgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

   // The back end never stalls, so the queue must never fill.
   assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("queue filled although the back end drains it every cycle");

   // Every accepted transaction produces its result strobe at the expected time.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##6 rsp_valid)
      else $error("accepted transaction produced no result at the expected cycle");

   // A result never appears without a transaction accepted at the matching time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 6))
      else $error("result strobe without a matching transaction");

   // Zero saturation must come out as grey.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_sat_pct == '0) |->
         ##6 (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("zero saturation did not produce grey");

endmodule

`default_nettype wire
